// ----- hw/rtl/mersenne_twister_generator_macros.svh -----
// Assertion macros for the mersenne_twister_generator block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is active
`define MTG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset
`define MTG_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTG_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTG_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/mtg_pkg.sv -----
// Shared types, constants and the output tempering function of the MT19937 generator.
// No dependencies; used by mersenne_twister_generator.
`default_nettype none

package mtg_pkg;

  // Command codes of an input beat
  localparam logic CmdSeed = 1'b0;
  localparam logic CmdDraw = 1'b1;

  // Fixed arithmetic constants
  localparam logic [31:0] SeedMult   = 32'd69069;
  localparam logic [31:0] TemperB    = 32'h9d2c5680;
  localparam logic [31:0] TemperC    = 32'hefc60000;
  localparam logic [31:0] TwistReset = 32'h9908b0df;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StSeed,
    StTwPrime,
    StTwRun,
    StTwDrain,
    StDrawRd,
    StDrawWb
  } state_e;

  // Temper one state word into an output word
  function automatic logic [31:0] temper(input logic [31:0] word);
    logic [31:0] y;
    y = word;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mtg_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read during write to the same address returns the old word. No dependencies.
`default_nettype none

module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic                     re_b_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports; data holds while a port is not enabled
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mersenne_twister_generator.sv -----
// MT19937 generator: a seed command stores the seed as word 0, then fills the other words, one
// word a cycle; a draw reads its word in StDrawRd and registers it tempered in StDrawWb, which
// waits while the output stalls; new beats wait for StIdle. A seeded draw that finds the index
// at STATE_WORDS first twists the state in StTwPrime, StTwRun and StTwDrain, one word per cycle
// through the two read ports and one write port of the state RAM. Reset clears control state
// at once with no clearing pass; the RAM is not cleared; unseeded draws return zero.
`default_nettype none

`include "mersenne_twister_generator_macros.svh"

module mersenne_twister_generator #(
  parameter int STATE_WORDS   = 624,
  parameter int MIDDLE_OFFSET = 397
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [31:0] seed_value_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      random_word_o
);

  localparam int AW = $clog2(STATE_WORDS);
  localparam int IW = $clog2(STATE_WORDS + 1);
  localparam logic [AW-1:0] LastAddr = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] MidOff   = AW'(MIDDLE_OFFSET % STATE_WORDS);
  localparam logic [IW-1:0] IdxFull  = IW'(STATE_WORDS);

  mtg_pkg::state_e state_q, state_d;

  logic          seeded_q, seeded_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [AW-1:0] iss_q, iss_d;
  logic [AW-1:0] mid_q, mid_d;
  logic [AW-1:0] wr_q;
  logic          cv_q;
  logic [31:0]   tc_q;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_q, out_d;
  logic [31:0]   cur_q, cur_d;
  logic [31:0]   prev_q, prev_d;
  logic          fwd_a_q, fwd_b_q;
  logic [31:0]   fwd_data_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re_a, ram_re_b;
  logic [AW-1:0] ram_addr_a, ram_addr_b;
  logic [31:0]   ram_rdata_a, ram_rdata_b;

  logic          in_accept;
  logic          out_ready;
  logic [31:0]   a_eff, b_eff;
  logic [31:0]   y_mix;
  logic [31:0]   twist_word;
  logic [31:0]   seed_next;
  logic [31:0]   draw_word;
  logic [AW-1:0] nxt_addr;

  // State memory
  mtg_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_state_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_a_i   (ram_re_a),
    .raddr_a_i(ram_addr_a),
    .rdata_a_o(ram_rdata_a),
    .re_b_i   (ram_re_b),
    .raddr_b_i(ram_addr_b),
    .rdata_b_o(ram_rdata_b)
  );

  // Take the word being written in the read cycle when addresses collided
  assign a_eff = fwd_a_q ? fwd_data_q : ram_rdata_a;
  assign b_eff = fwd_b_q ? fwd_data_q : ram_rdata_b;

  // Twist datapath
  assign y_mix      = {cur_q[31], a_eff[30:0]};
  assign twist_word = b_eff ^ {1'b0, y_mix[31:1]} ^ (y_mix[0] ? tc_q : 32'd0);

  // Seed recurrence, truncated to 32 bits
  assign seed_next = 32'(prev_q * mtg_pkg::SeedMult);

  assign draw_word = seeded_q ? a_eff : 32'd0;
  assign nxt_addr  = (iss_q == LastAddr) ? '0 : AW'(iss_q + 1'b1);

  assign in_stall_o = (state_q != mtg_pkg::StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_ready  = !out_valid_q || !out_stall_i;

  // Sequencer: next state, RAM control and register updates
  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    mid_d       = mid_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = cv_q;
    ram_waddr   = wr_q;
    ram_wdata   = twist_word;
    ram_re_a    = 1'b0;
    ram_addr_a  = '0;
    ram_re_b    = 1'b0;
    ram_addr_b  = '0;

    unique case (state_q)
      mtg_pkg::StIdle: begin
        if (in_accept) begin
          if (command_i == mtg_pkg::CmdSeed) begin
            // Store the seed as word 0 and start the fill
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_value_i;
            prev_d    = seed_value_i;
            iss_d     = AW'(1);
            seeded_d  = 1'b1;
            state_d   = mtg_pkg::StSeed;
          end else if (seeded_q && (idx_q == IdxFull)) begin
            state_d = mtg_pkg::StTwPrime;
          end else begin
            state_d = mtg_pkg::StDrawRd;
          end
        end
      end
      mtg_pkg::StSeed: begin
        // Write one seeded word per cycle
        ram_we    = 1'b1;
        ram_waddr = iss_q;
        ram_wdata = seed_next;
        prev_d    = seed_next;
        iss_d     = AW'(iss_q + 1'b1);
        if (iss_q == LastAddr) begin
          idx_d   = IdxFull;
          state_d = mtg_pkg::StIdle;
        end
      end
      mtg_pkg::StTwPrime: begin
        // Fetch word 0 ahead of the first twist step
        ram_re_a   = 1'b1;
        ram_addr_a = '0;
        iss_d      = '0;
        mid_d      = MidOff;
        state_d    = mtg_pkg::StTwRun;
      end
      mtg_pkg::StTwRun: begin
        // Issue reads for step iss_q, finish the previous step
        ram_re_a   = 1'b1;
        ram_addr_a = nxt_addr;
        ram_re_b   = 1'b1;
        ram_addr_b = mid_q;
        cur_d      = a_eff;
        iss_d      = AW'(iss_q + 1'b1);
        mid_d      = (mid_q == LastAddr) ? '0 : AW'(mid_q + 1'b1);
        if (iss_q == LastAddr) begin
          state_d = mtg_pkg::StTwDrain;
        end
      end
      mtg_pkg::StTwDrain: begin
        // Last word written here; restart reading at word 0
        idx_d   = '0;
        state_d = mtg_pkg::StDrawRd;
      end
      mtg_pkg::StDrawRd: begin
        ram_re_a   = seeded_q;
        ram_addr_a = idx_q[AW-1:0];
        state_d    = mtg_pkg::StDrawWb;
      end
      mtg_pkg::StDrawWb: begin
        // Hold the read word until the output register frees up
        if (out_ready) begin
          out_d       = mtg_pkg::temper(draw_word);
          out_valid_d = 1'b1;
          if (seeded_q) begin
            idx_d = IW'(idx_q + 1'b1);
          end
          state_d = mtg_pkg::StIdle;
        end
      end
      default: begin
        state_d = mtg_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtg_pkg::StIdle;
      seeded_q    <= 1'b0;
      idx_q       <= IdxFull;
      iss_q       <= '0;
      mid_q       <= '0;
      wr_q        <= '0;
      cv_q        <= 1'b0;
      tc_q        <= mtg_pkg::TwistReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      idx_q       <= idx_d;
      iss_q       <= iss_d;
      mid_q       <= mid_d;
      wr_q        <= iss_q;
      cv_q        <= (state_q == mtg_pkg::StTwRun);
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tc_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    fwd_data_q <= ram_wdata;
    if (ram_re_a) begin
      fwd_a_q <= ram_we && (ram_addr_a == ram_waddr);
    end
    if (ram_re_b) begin
      fwd_b_q <= ram_we && (ram_addr_b == ram_waddr);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_q;

  // Checks
  `MTG_ASSERT(a_out_from_wb, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == mtg_pkg::StDrawWb), "output beat not produced by draw writeback")
  `MTG_ASSERT(a_idx_in_range, clk_i, rst_ni, (state_q == mtg_pkg::StDrawRd && seeded_q) |-> (idx_q < IdxFull), "draw read index past end of state")
  `MTG_ASSERT(a_drain_to_draw, clk_i, rst_ni, (state_q == mtg_pkg::StTwDrain) |=> (state_q == mtg_pkg::StDrawRd && idx_q == '0), "twist did not hand over to a draw at word 0")
  `MTG_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |-> (state_q == mtg_pkg::StIdle && !out_valid_q), "control state not cleared in reset")

endmodule

`default_nettype wire
